>>> rtl/mm_pkg.sv
// Shared types and constants for the fixed-point matrix multiplier.
package mm_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_A_ROWS    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_B_COLS    = 2'd2;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Register reset value shared by all three dimensions.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // Accumulator width and its saturation bounds (plus and minus 2^62).
  localparam int ACC_W = 64;
  localparam logic signed [ACC_W:0] ACC_HI = 65'sh4000_0000_0000_0000;
  localparam logic signed [ACC_W:0] ACC_LO = -65'sh4000_0000_0000_0000;

  // Bounds of the signed 32-bit result range.
  localparam logic signed [ACC_W-1:0] RES_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] RES_MIN = -64'sh0000_0000_8000_0000;

  // One input item.
  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] product_value;
    logic               last;
  } out_item_t;

endpackage

>>> rtl/matrix_multiply_top.sv
// Matrix multiplier top level: element stores, MAC sequencer and output register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   mm_pkg::in_item_t (op, row, col, element)
//   out_     output     out_valid/out_stall mm_pkg::out_item_t (row, col, value, last)
//   cfg_     input      cfg_we              cfg_index, cfg_wdata (4 bits)
//
// A write item (op 0 or 1) writes one memory entry.
// A compute item produces a_rows * b_cols product elements in turn: each product
// element issues inner_dim reads on the single read port of each store, then waits
// for the read and multiply registers and then loads the output register.
// With inner_dim zero it only loads the output register. Output stalls hold the load.
// Synchronous active-low reset; the stores hold no reset and no clearing pass runs.
// in_stall is high while a compute runs; items are taken again once it ends.
module matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mm_pkg::in_item_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mm_pkg::out_item_t              out_data,
  input  logic                           cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = DATA_WIDTH;
  localparam int LW    = 7;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [mm_pkg::CFG_DATA_W-1:0] MAX_DIM_C = mm_pkg::CFG_DATA_W'(MAX_DIM);

  // Element stores.
  logic [DW-1:0] mem_a [DEPTH];
  logic [DW-1:0] mem_b [DEPTH];

  logic [mm_pkg::CFG_DATA_W-1:0] a_rows_r, inner_dim_r, b_cols_r;
  logic [mm_pkg::CFG_DATA_W-1:0] m_r, n_r, p_r, m_nxt, n_nxt, p_nxt;
  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic signed [DW-1:0] rd_a_r, rd_b_r;
  logic          rd_v_r, rd_last_r;
  logic signed [2*DW-1:0] prod_full;
  logic signed [mm_pkg::ACC_W-1:0] prod_r, acc_r, acc_nxt;
  logic          prod_v_r, prod_last_r;
  logic signed [mm_pkg::ACC_W:0] acc_sum, acc_sat;
  logic          out_valid_r, out_valid_nxt;
  mm_pkg::out_item_t out_data_r, out_data_nxt;
  logic [31:0]   elem_ext;
  logic [LW-1:0] wr_lin, rd_a_lin, rd_b_lin;
  logic          in_take, wr_ok, issue, last_k, last_i, last_j, out_free, load_out;
  logic signed [31:0] res_sat;

  // Dimension actually used: register value limited to MAX_DIM.
  function automatic logic [mm_pkg::CFG_DATA_W-1:0] dim_of(
    input logic [mm_pkg::CFG_DATA_W-1:0] v
  );
    return (v > MAX_DIM_C) ? MAX_DIM_C : v;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      b_cols_r    <= mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mm_pkg::REG_A_ROWS)    a_rows_r    <= cfg_wdata;
      if (cfg_index == mm_pkg::REG_INNER_DIM) inner_dim_r <= cfg_wdata;
      if (cfg_index == mm_pkg::REG_B_COLS)    b_cols_r    <= cfg_wdata;
    end
  end

  // Write path: elements are taken as unsigned 16-bit values and cut to the store width.
  assign elem_ext = {16'b0, in_data.element};
  assign wr_ok    = ({1'b0, in_data.row_index} < MAX_DIM_C) &&
                    ({1'b0, in_data.col_index} < MAX_DIM_C);
  assign wr_lin   = LW'(in_data.row_index) * LW'(MAX_DIM) + LW'(in_data.col_index);

  always_ff @(posedge clk) begin
    if (in_take && wr_ok && (in_data.op == mm_pkg::OP_WRITE_A)) begin
      mem_a[wr_lin[AW-1:0]] <= elem_ext[DW-1:0];
    end
    if (in_take && wr_ok && (in_data.op == mm_pkg::OP_WRITE_B)) begin
      mem_b[wr_lin[AW-1:0]] <= elem_ext[DW-1:0];
    end
  end

  // Read path: A walks along row i, B walks down column j.
  assign rd_a_lin = LW'(i_r) * LW'(MAX_DIM) + LW'(k_r);
  assign rd_b_lin = LW'(k_r) * LW'(MAX_DIM) + LW'(j_r);

  always_ff @(posedge clk) begin
    rd_a_r <= mem_a[rd_a_lin[AW-1:0]];
    rd_b_r <= mem_b[rd_b_lin[AW-1:0]];
  end

  // Multiply stage.
  assign prod_full = rd_a_r * rd_b_r;

  always_ff @(posedge clk) begin
    prod_r <= mm_pkg::ACC_W'(prod_full);
  end

  // Accumulate with saturation at plus and minus 2^62.
  assign acc_sum = (mm_pkg::ACC_W + 1)'(acc_r) + (mm_pkg::ACC_W + 1)'(prod_r);
  always_comb begin
    priority if (acc_sum > mm_pkg::ACC_HI) begin
      acc_sat = mm_pkg::ACC_HI;
    end else if (acc_sum < mm_pkg::ACC_LO) begin
      acc_sat = mm_pkg::ACC_LO;
    end else begin
      acc_sat = acc_sum;
    end
  end

  // Final saturation to the signed 32-bit range.
  always_comb begin
    priority if (acc_r > mm_pkg::RES_MAX) begin
      res_sat = 32'(mm_pkg::RES_MAX);
    end else if (acc_r < mm_pkg::RES_MIN) begin
      res_sat = 32'(mm_pkg::RES_MIN);
    end else begin
      res_sat = acc_r[31:0];
    end
  end

  assign issue    = (state_r == ST_ISSUE);
  assign last_k   = ((mm_pkg::CFG_DATA_W'(k_r) + 4'd1) == n_r);
  assign last_i   = ((mm_pkg::CFG_DATA_W'(i_r) + 4'd1) == m_r);
  assign last_j   = ((mm_pkg::CFG_DATA_W'(j_r) + 4'd1) == p_r);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_FINISH) && out_free;

  // Sequencer over product elements and the inner dimension.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (prod_v_r) begin
      acc_nxt = mm_pkg::ACC_W'(acc_sat);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_data.op == mm_pkg::OP_COMPUTE)) begin
          m_nxt   = dim_of(a_rows_r);
          n_nxt   = dim_of(inner_dim_r);
          p_nxt   = dim_of(b_cols_r);
          i_nxt   = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          acc_nxt = '0;
          if ((m_nxt == '0) || (p_nxt == '0)) begin
            state_nxt = ST_IDLE;
          end else if (n_nxt == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (prod_v_r && prod_last_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_row       = 3'(i_r);
          out_data_nxt.out_col       = 3'(j_r);
          out_data_nxt.product_value = res_sat;
          out_data_nxt.last          = last_i && last_j;
          acc_nxt                    = '0;
          k_nxt                      = '0;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          if (last_i && last_j) begin
            state_nxt = ST_IDLE;
          end else if (n_r == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      prod_v_r    <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and counter registers.
  always_ff @(posedge clk) begin
    rd_last_r   <= last_k;
    prod_last_r <= rd_last_r;
    acc_r       <= acc_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    m_r         <= m_nxt;
    n_r         <= n_nxt;
    p_r         <= p_nxt;
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> rtl/matrix_multiply_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
module matrix_multiply_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input mm_pkg::in_item_t               in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input mm_pkg::out_item_t              out_data
);

  // A stalled result item stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  // The block only goes busy after taking a compute item.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall && (in_data.op == mm_pkg::OP_COMPUTE)))
    else $error("input stalled without a compute item");

  // While idle no new result can appear in the next cycle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result item appeared without a compute run");

  // A result that shows up as the block goes idle closes its run.
  a_last_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !in_stall |-> out_data.last)
    else $error("run ended without a last result item");

endmodule

bind matrix_multiply_top matrix_multiply_checker u_checker (.*);
